// ===== design/ataseq_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Shared types and constants: input kinds, result actions, port addresses,
// status bits and the descriptor passed from the control unit to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ataseq_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_START_READ  = 2'd0;
	localparam logic [1:0] KIND_START_WRITE = 2'd1;
	localparam logic [1:0] KIND_STATUS      = 2'd2;
	localparam logic [1:0] KIND_DATA        = 2'd3;

	// Result actions.
	typedef enum logic [2:0] {
		ACT_REG_WRITE   = 3'd0,
		ACT_REG_READ    = 3'd1,
		ACT_BURST_READ  = 3'd2,
		ACT_FETCH_HOST  = 3'd3,
		ACT_WORD_HOST   = 3'd4,
		ACT_WORD_DRIVE  = 3'd5,
		ACT_DONE        = 3'd6,
		ACT_ERROR       = 3'd7
	} action_t;

	// I/O ports of the primary bus.
	localparam logic [9:0] PORT_BASE  = 10'h1F0;
	localparam logic [9:0] PORT_ERR   = 10'h1F1;
	localparam logic [9:0] PORT_COUNT = 10'h1F2;
	localparam logic [9:0] PORT_LBA0  = 10'h1F3;
	localparam logic [9:0] PORT_LBA1  = 10'h1F4;
	localparam logic [9:0] PORT_LBA2  = 10'h1F5;
	localparam logic [9:0] PORT_DRIVE = 10'h1F6;
	localparam logic [9:0] PORT_CMD   = 10'h1F7;
	localparam logic [9:0] PORT_CTRL  = 10'h3F6;
	localparam logic [9:0] PORT_NONE  = 10'h000;

	// Register values and commands.
	localparam logic [7:0] DRIVE_SEL_LBA   = 8'hE0;
	localparam logic [7:0] CMD_READ        = 8'h20;
	localparam logic [7:0] CMD_WRITE       = 8'h30;
	localparam logic [7:0] CMD_CACHE_FLUSH = 8'hE7;

	// Status register bits.
	localparam int ST_BSY = 7;
	localparam int ST_DF  = 5;
	localparam int ST_DRQ = 3;
	localparam int ST_ERR = 0;

	// Error codes.
	localparam logic [15:0] ERR_DEVICE  = 16'd0;
	localparam logic [15:0] ERR_TIMEOUT = 16'd1;

	localparam int          LBA_W            = 28;
	localparam int          POLL_W           = 20;
	localparam logic [19:0] POLL_MAX         = 20'hFFFFF;
	localparam logic [19:0] POLL_LIMIT_RESET = 20'd1000000;
	localparam logic [15:0] WORDS_PER_SECTOR = 16'd256;
	localparam logic [7:0]  LAST_WORD_INDEX  = 8'd255;

	// What one accepted item asks the emitter to produce.
	typedef enum logic [2:0] {
		OP_DONE  = 3'd0,
		OP_ERR   = 3'd1,
		OP_CHUNK = 3'd2,
		OP_BURST = 3'd3,
		OP_WORD  = 3'd4
	} op_t;

	// What follows the settle reads at the end of a sector.
	typedef enum logic [1:0] {
		TAIL_NONE  = 2'd0,
		TAIL_FLUSH = 2'd1,
		TAIL_DONE  = 2'd2
	} tail_t;

	typedef struct packed {
		op_t               op;
		tail_t             tail;
		logic              is_write;
		logic              timeout;
		logic              sector_end;
		logic [LBA_W-1:0]  lba;
		logic [7:0]        chunk;
		logic [15:0]       word;
	} desc_t;

endpackage

`default_nettype wire

// ===== design/ataseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer control
// Holds the request state and the poll limit, updates them for each accepted
// item and hands a descriptor of the results to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ataseq_ctrl #(
	parameter int MAX_CHUNK = 255
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    kind,
	input  wire logic [ataseq_pkg::LBA_W-1:0]  start_lba,
	input  wire logic [15:0]                   sector_count,
	input  wire logic [7:0]                    status_byte,
	input  wire logic [15:0]                   data_word,
	input  wire logic                          cfg_we,
	input  wire logic [ataseq_pkg::POLL_W-1:0] cfg_wdata,
	output logic                               desc_valid,
	output ataseq_pkg::desc_t                  desc
);

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_WAIT_READY = 5'b00010,
		PH_WAIT_DRQ   = 5'b00100,
		PH_DATA       = 5'b01000,
		PH_WAIT_FLUSH = 5'b10000
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic                            is_write_q, is_write_d;
	logic [ataseq_pkg::LBA_W-1:0]    next_lba_q, next_lba_d;
	logic [15:0]                     sectors_left_q, sectors_left_d;
	logic [7:0]                      chunk_left_q, chunk_left_d;
	logic [7:0]                      word_index_q, word_index_d;
	logic [ataseq_pkg::POLL_W-1:0]   poll_count_q, poll_count_d;
	logic [ataseq_pkg::POLL_W-1:0]   poll_limit_q;

	logic [ataseq_pkg::POLL_W-1:0]   poll_inc;
	logic                            timeout;
	logic                            st_bsy, st_fault, st_drq;
	logic [7:0]                      chunk;
	logic [7:0]                      chunk_dec;

	assign poll_inc = (poll_count_q < ataseq_pkg::POLL_MAX) ?
		poll_count_q + 1'b1 : poll_count_q;
	// A limit of zero behaves like one, since the incremented count is never zero.
	assign timeout  = (poll_inc >= poll_limit_q);
	assign st_bsy   = status_byte[ataseq_pkg::ST_BSY];
	assign st_drq   = status_byte[ataseq_pkg::ST_DRQ];
	assign st_fault = status_byte[ataseq_pkg::ST_ERR] | status_byte[ataseq_pkg::ST_DF];
	assign chunk    = (sectors_left_q > 16'(MAX_CHUNK)) ? 8'(MAX_CHUNK) : sectors_left_q[7:0];
	assign chunk_dec = (chunk_left_q != 8'd0) ? chunk_left_q - 8'd1 : chunk_left_q;

	always_comb begin
		phase_d        = phase_q;
		is_write_d     = is_write_q;
		next_lba_d     = next_lba_q;
		sectors_left_d = sectors_left_q;
		chunk_left_d   = chunk_left_q;
		word_index_d   = word_index_q;
		poll_count_d   = poll_count_q;
		desc_valid     = 1'b0;
		desc           = '0;
		desc.is_write  = is_write_q;
		desc.lba       = next_lba_q;
		desc.chunk     = chunk;
		desc.word      = data_word;

		case (kind)
			ataseq_pkg::KIND_START_READ, ataseq_pkg::KIND_START_WRITE: begin
				if (phase_q == PH_IDLE) begin
					is_write_d     = (kind == ataseq_pkg::KIND_START_WRITE);
					next_lba_d     = start_lba;
					sectors_left_d = sector_count;
					chunk_left_d   = 8'd0;
					word_index_d   = 8'd0;
					if (sector_count == 16'd0) begin
						desc_valid = 1'b1;
						desc.op    = ataseq_pkg::OP_DONE;
					end else begin
						phase_d      = PH_WAIT_READY;
						poll_count_d = '0;
					end
				end
			end
			ataseq_pkg::KIND_STATUS: begin
				if (phase_q == PH_WAIT_READY || phase_q == PH_WAIT_FLUSH) begin
					poll_count_d = poll_inc;
					if (st_bsy) begin
						if (timeout) begin
							desc_valid   = 1'b1;
							desc.op      = ataseq_pkg::OP_ERR;
							desc.timeout = 1'b1;
							phase_d      = PH_IDLE;
						end
					end else if (st_fault) begin
						desc_valid = 1'b1;
						desc.op    = ataseq_pkg::OP_ERR;
						phase_d    = PH_IDLE;
					end else if (phase_q == PH_WAIT_READY) begin
						desc_valid     = 1'b1;
						desc.op        = ataseq_pkg::OP_CHUNK;
						next_lba_d     = next_lba_q + ataseq_pkg::LBA_W'(chunk);
						sectors_left_d = sectors_left_q - 16'(chunk);
						chunk_left_d   = chunk;
						poll_count_d   = '0;
						phase_d        = PH_WAIT_DRQ;
					end else if (sectors_left_q == 16'd0) begin
						desc_valid = 1'b1;
						desc.op    = ataseq_pkg::OP_DONE;
						phase_d    = PH_IDLE;
					end else begin
						phase_d      = PH_WAIT_READY;
						poll_count_d = '0;
					end
				end else if (phase_q == PH_WAIT_DRQ) begin
					poll_count_d = poll_inc;
					// A fault counts here even while the drive reports busy.
					if (st_fault) begin
						desc_valid = 1'b1;
						desc.op    = ataseq_pkg::OP_ERR;
						phase_d    = PH_IDLE;
					end else if (!st_bsy && st_drq) begin
						desc_valid   = 1'b1;
						desc.op      = ataseq_pkg::OP_BURST;
						word_index_d = 8'd0;
						phase_d      = PH_DATA;
					end else if (timeout) begin
						desc_valid   = 1'b1;
						desc.op      = ataseq_pkg::OP_ERR;
						desc.timeout = 1'b1;
						phase_d      = PH_IDLE;
					end
				end
			end
			ataseq_pkg::KIND_DATA: begin
				if (phase_q == PH_DATA) begin
					desc_valid = 1'b1;
					desc.op    = ataseq_pkg::OP_WORD;
					if (word_index_q != ataseq_pkg::LAST_WORD_INDEX) begin
						word_index_d = word_index_q + 8'd1;
					end else begin
						word_index_d    = 8'd0;
						desc.sector_end = 1'b1;
						chunk_left_d    = chunk_dec;
						poll_count_d    = '0;
						if (chunk_dec != 8'd0) begin
							phase_d = PH_WAIT_DRQ;
						end else if (is_write_q) begin
							desc.tail = ataseq_pkg::TAIL_FLUSH;
							phase_d   = PH_WAIT_FLUSH;
						end else if (sectors_left_q == 16'd0) begin
							desc.tail = ataseq_pkg::TAIL_DONE;
							phase_d   = PH_IDLE;
						end else begin
							phase_d = PH_WAIT_READY;
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (!accept) begin
			desc_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			is_write_q     <= 1'b0;
			next_lba_q     <= '0;
			sectors_left_q <= '0;
			chunk_left_q   <= '0;
			word_index_q   <= '0;
			poll_count_q   <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			is_write_q     <= is_write_d;
			next_lba_q     <= next_lba_d;
			sectors_left_q <= sectors_left_d;
			chunk_left_q   <= chunk_left_d;
			word_index_q   <= word_index_d;
			poll_count_q   <= poll_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= ataseq_pkg::POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			poll_limit_q <= cfg_wdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/ataseq_emit.sv =====
// ----------------------------------------------------------------------------
// ATA PIO sequencer result emitter
// Buffers one descriptor and expands the current one into result items,
// one per output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ataseq_emit #(
	parameter int SETTLE_READS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               desc_valid,
	input  wire ataseq_pkg::desc_t  desc,
	output logic                    desc_ready,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              action,
	output logic [9:0]              port,
	output logic [15:0]             value,
	output logic                    last
);

	localparam int STEP_W = $clog2(SETTLE_READS + 8);
	localparam logic [STEP_W-1:0] SR = STEP_W'(SETTLE_READS);

	ataseq_pkg::desc_t   pend_q, cur_q;
	logic                pend_v_q, cur_v_q;
	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   rel;
	logic                fin, load;
	ataseq_pkg::action_t act;

	assign fin        = cur_v_q && !out_stall && last;
	assign load       = pend_v_q && (!cur_v_q || fin);
	assign desc_ready = !pend_v_q || load;
	assign out_valid  = cur_v_q;
	assign action     = act;
	assign rel        = step_q - SR;

	always_comb begin
		act   = ataseq_pkg::ACT_REG_WRITE;
		port  = ataseq_pkg::PORT_NONE;
		value = 16'd0;
		last  = 1'b1;
		case (cur_q.op)
			ataseq_pkg::OP_DONE: begin
				act = ataseq_pkg::ACT_DONE;
			end
			ataseq_pkg::OP_ERR: begin
				act   = ataseq_pkg::ACT_ERROR;
				value = cur_q.timeout ? ataseq_pkg::ERR_TIMEOUT : ataseq_pkg::ERR_DEVICE;
			end
			ataseq_pkg::OP_BURST: begin
				act   = cur_q.is_write ? ataseq_pkg::ACT_FETCH_HOST :
					ataseq_pkg::ACT_BURST_READ;
				port  = ataseq_pkg::PORT_BASE;
				value = ataseq_pkg::WORDS_PER_SECTOR;
			end
			ataseq_pkg::OP_CHUNK: begin
				last = 1'b0;
				if (step_q == '0) begin
					port  = ataseq_pkg::PORT_DRIVE;
					value = {8'd0, ataseq_pkg::DRIVE_SEL_LBA | {4'd0, cur_q.lba[27:24]}};
				end else if (step_q <= SR) begin
					act  = ataseq_pkg::ACT_REG_READ;
					port = ataseq_pkg::PORT_CTRL;
				end else begin
					case (rel)
						STEP_W'(1): begin
							port = ataseq_pkg::PORT_ERR;
						end
						STEP_W'(2): begin
							port  = ataseq_pkg::PORT_COUNT;
							value = {8'd0, cur_q.chunk};
						end
						STEP_W'(3): begin
							port  = ataseq_pkg::PORT_LBA0;
							value = {8'd0, cur_q.lba[7:0]};
						end
						STEP_W'(4): begin
							port  = ataseq_pkg::PORT_LBA1;
							value = {8'd0, cur_q.lba[15:8]};
						end
						STEP_W'(5): begin
							port  = ataseq_pkg::PORT_LBA2;
							value = {8'd0, cur_q.lba[23:16]};
						end
						default: begin
							port  = ataseq_pkg::PORT_CMD;
							value = {8'd0, cur_q.is_write ? ataseq_pkg::CMD_WRITE :
								ataseq_pkg::CMD_READ};
							last  = 1'b1;
						end
					endcase
				end
			end
			ataseq_pkg::OP_WORD: begin
				if (step_q == '0) begin
					act   = cur_q.is_write ? ataseq_pkg::ACT_WORD_DRIVE :
						ataseq_pkg::ACT_WORD_HOST;
					port  = ataseq_pkg::PORT_BASE;
					value = cur_q.word;
					last  = !cur_q.sector_end;
				end else if (step_q <= SR) begin
					act  = ataseq_pkg::ACT_REG_READ;
					port = ataseq_pkg::PORT_CTRL;
					last = (step_q == SR) && (cur_q.tail == ataseq_pkg::TAIL_NONE);
				end else if (cur_q.tail == ataseq_pkg::TAIL_FLUSH) begin
					port  = ataseq_pkg::PORT_CMD;
					value = {8'd0, ataseq_pkg::CMD_CACHE_FLUSH};
				end else begin
					act = ataseq_pkg::ACT_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			cur_v_q  <= 1'b0;
			step_q   <= '0;
		end else begin
			if (desc_valid && desc_ready) begin
				pend_v_q <= 1'b1;
			end else if (load) begin
				pend_v_q <= 1'b0;
			end
			if (load) begin
				cur_v_q <= 1'b1;
				step_q  <= '0;
			end else if (fin) begin
				cur_v_q <= 1'b0;
			end else if (cur_v_q && !out_stall) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_valid && desc_ready) begin
			pend_q <= desc;
		end
		if (load) begin
			cur_q <= pend_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/ata_pio_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// ATA PIO LBA28 host sequencer
// Splits read and write requests into drive commands and data transfers.
// ----------------------------------------------------------------------------
// The input channel carries requests, polled status bytes and data words,
// selected by kind. The output channel carries one register access, data
// word, done or error report per item, with last marking the final result
// of each input item. Both channels move an item when valid is high and
// stall is low.
// Each input item updates the request state in the cycle it is accepted and
// becomes a descriptor, registered in the buffer and then the current slot
// before its first result. Items that cause at most one result flow at one
// per cycle while out_stall is low. A chunk setup emits 7 + SETTLE_READS
// results and the end of a sector 1 + SETTLE_READS, or one more with a
// flush or done, one per output cycle; the result emitter sets the pace.
// One descriptor waits in a buffer while the emitter works, so a new item
// is taken while results are still pending. When the receiver stalls, the
// current result holds and input stalls once the buffer is full. Reset
// returns the sequencer to idle with a poll limit of 1000000; cfg_we writes
// a new poll limit; the user must do so only while idle; nothing checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_pio_host_sequencer #(
	parameter int MAX_CHUNK    = 255,
	parameter int SETTLE_READS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [27:0] start_lba,
	input  wire logic [15:0] sector_count,
	input  wire logic [7:0]  status_byte,
	input  wire logic [15:0] data_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       action,
	output logic [9:0]       port,
	output logic [15:0]      value,
	output logic             last
);

	logic              accept;
	logic              desc_valid;
	logic              desc_ready;
	ataseq_pkg::desc_t desc;

	assign in_stall = !desc_ready;
	assign accept   = in_valid && desc_ready;

	ataseq_ctrl #(
		.MAX_CHUNK(MAX_CHUNK)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.start_lba   (start_lba),
		.sector_count(sector_count),
		.status_byte (status_byte),
		.data_word   (data_word),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.desc_valid  (desc_valid),
		.desc        (desc)
	);

	ataseq_emit #(
		.SETTLE_READS(SETTLE_READS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid),
		.desc      (desc),
		.desc_ready(desc_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.action    (action),
		.port      (port),
		.value     (value),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ATA PIO sequencer testbench
// Drives requests, status polls and data words into the sequencer and checks
// every register access, data word, done and error it emits. The expected
// accesses come from a cycle-free model of the request state kept in a small
// tracker class, checked in order, field by field.
// ----------------------------------------------------------------------------

module testbench;

	localparam int CHUNK_MAX    = 255;
	localparam int SETTLE_N     = 4;
	localparam int DRAIN_CYCLES = 16;
	localparam int WATCHDOG_NS  = 4000000;

	typedef enum logic [4:0] {
		SEQ_IDLE       = 5'b00001,
		SEQ_WAIT_READY = 5'b00010,
		SEQ_WAIT_DRQ   = 5'b00100,
		SEQ_DATA       = 5'b01000,
		SEQ_WAIT_FLUSH = 5'b10000
	} seq_state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [9:0]  port;
		logic [15:0] value;
		logic        last;
	} access_t;

	// Tracks the request state and the accesses it owes to the bus.
	class access_tracker_t;
		logic [19:0]  limit;
		seq_state_t   state;
		logic         is_write;
		logic [27:0]  next_lba;
		logic [15:0]  sectors_left;
		logic [7:0]   chunk_left;
		int           word_index;
		logic [19:0]  poll_count;
		access_t      expected[$];
		int           mismatches, checked, items_seen, ignored;
		int           n_chunk, n_sector, n_flush, n_done, n_device, n_timeout;

		function new();
			limit = ataseq_pkg::POLL_LIMIT_RESET;
			state = SEQ_IDLE;
			is_write = 1'b0;
			next_lba = '0;
			sectors_left = '0;
			chunk_left = '0;
			word_index = 0;
			poll_count = '0;
		endfunction

		function int waiting();
			return expected.size();
		endfunction

		function void emit(ataseq_pkg::action_t a, logic [9:0] p, logic [15:0] v);
			access_t acc;
			acc = '{a, p, v, 1'b0};
			expected.push_back(acc);
			case (a)
				ataseq_pkg::ACT_DONE: n_done++;
				ataseq_pkg::ACT_ERROR: begin
					if (v == ataseq_pkg::ERR_TIMEOUT) n_timeout++; else n_device++;
				end
				ataseq_pkg::ACT_BURST_READ, ataseq_pkg::ACT_FETCH_HOST: n_sector++;
				default: ;
			endcase
		endfunction

		function void settle_reads();
			repeat (SETTLE_N) emit(ataseq_pkg::ACT_REG_READ, ataseq_pkg::PORT_CTRL, 16'd0);
		endfunction

		function void abort(logic [15:0] code);
			state = SEQ_IDLE;
			emit(ataseq_pkg::ACT_ERROR, ataseq_pkg::PORT_NONE, code);
		endfunction

		function void finish_or_continue();
			if (sectors_left == 0) begin
				state = SEQ_IDLE;
				emit(ataseq_pkg::ACT_DONE, ataseq_pkg::PORT_NONE, 16'd0);
			end else begin
				state = SEQ_WAIT_READY;
				poll_count = '0;
			end
		endfunction

		function void begin_chunk();
			logic [7:0] chunk;
			chunk = (sectors_left > CHUNK_MAX) ? 8'(CHUNK_MAX) : sectors_left[7:0];
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_DRIVE,
				{8'h00, ataseq_pkg::DRIVE_SEL_LBA | {4'h0, next_lba[27:24]}});
			settle_reads();
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_ERR, 16'd0);
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_COUNT, {8'h00, chunk});
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_LBA0, {8'h00, next_lba[7:0]});
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_LBA1, {8'h00, next_lba[15:8]});
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_LBA2, {8'h00, next_lba[23:16]});
			emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_CMD,
				{8'h00, is_write ? ataseq_pkg::CMD_WRITE : ataseq_pkg::CMD_READ});
			next_lba = next_lba + 28'(chunk);
			sectors_left = sectors_left - 16'(chunk);
			chunk_left = chunk;
			poll_count = '0;
			state = SEQ_WAIT_DRQ;
			n_chunk++;
		endfunction

		function void take_status(logic [7:0] s);
			if (poll_count < ataseq_pkg::POLL_MAX)
				poll_count++;
			if (state == SEQ_WAIT_READY || state == SEQ_WAIT_FLUSH) begin
				if (s[ataseq_pkg::ST_BSY]) begin
					if (poll_count >= limit)
						abort(ataseq_pkg::ERR_TIMEOUT);
				end else if (s[ataseq_pkg::ST_ERR] || s[ataseq_pkg::ST_DF])
					abort(ataseq_pkg::ERR_DEVICE);
				else if (state == SEQ_WAIT_READY)
					begin_chunk();
				else
					finish_or_continue();
			end else if (s[ataseq_pkg::ST_ERR] || s[ataseq_pkg::ST_DF]) begin
				abort(ataseq_pkg::ERR_DEVICE);
			end else if (!s[ataseq_pkg::ST_BSY] && s[ataseq_pkg::ST_DRQ]) begin
				state = SEQ_DATA;
				word_index = 0;
				emit(is_write ? ataseq_pkg::ACT_FETCH_HOST : ataseq_pkg::ACT_BURST_READ,
					ataseq_pkg::PORT_BASE, ataseq_pkg::WORDS_PER_SECTOR);
			end else if (poll_count >= limit) begin
				abort(ataseq_pkg::ERR_TIMEOUT);
			end
		endfunction

		function void take_word(logic [15:0] w);
			emit(is_write ? ataseq_pkg::ACT_WORD_DRIVE : ataseq_pkg::ACT_WORD_HOST,
				ataseq_pkg::PORT_BASE, w);
			word_index++;
			if (word_index < int'(ataseq_pkg::WORDS_PER_SECTOR))
				return;
			word_index = 0;
			settle_reads();
			if (chunk_left > 0)
				chunk_left--;
			poll_count = '0;
			if (chunk_left > 0)
				state = SEQ_WAIT_DRQ;
			else if (is_write) begin
				state = SEQ_WAIT_FLUSH;
				emit(ataseq_pkg::ACT_REG_WRITE, ataseq_pkg::PORT_CMD,
					{8'h00, ataseq_pkg::CMD_CACHE_FLUSH});
				n_flush++;
			end else
				finish_or_continue();
		endfunction

		// Works out the accesses caused by one accepted item.
		function void predict_item(logic [1:0] k, logic [27:0] lba, logic [15:0] cnt,
				logic [7:0] st, logic [15:0] w);
			int first;
			first = expected.size();
			items_seen++;
			case (k)
				ataseq_pkg::KIND_START_READ, ataseq_pkg::KIND_START_WRITE: begin
					if (state == SEQ_IDLE) begin
						is_write = (k == ataseq_pkg::KIND_START_WRITE);
						next_lba = lba;
						sectors_left = cnt;
						chunk_left = '0;
						word_index = 0;
						finish_or_continue();
					end else
						ignored++;
				end
				ataseq_pkg::KIND_STATUS: begin
					if (state == SEQ_WAIT_READY || state == SEQ_WAIT_DRQ ||
							state == SEQ_WAIT_FLUSH)
						take_status(st);
					else
						ignored++;
				end
				default: begin
					if (state == SEQ_DATA)
						take_word(w);
					else
						ignored++;
				end
			endcase
			if (expected.size() > first)
				expected[expected.size() - 1].last = 1'b1;
		endfunction

		function void check_access(access_t got);
			access_t want;
			if (expected.size() == 0) begin
				$error("result with nothing expected: action %0d port %0h value %0h last %0b",
					got.action, got.port, got.value, got.last);
				mismatches++;
				return;
			end
			want = expected.pop_front();
			checked++;
			if (got.action !== want.action) begin
				$error("action: expected %0d, got %0d", want.action, got.action);
				mismatches++;
			end
			if (got.port !== want.port) begin
				$error("port: expected %0h, got %0h", want.port, got.port);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$error("value: expected %0h, got %0h", want.value, got.value);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [19:0] cfg_wdata    = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  kind         = ataseq_pkg::KIND_STATUS;
	logic [27:0] start_lba    = '0;
	logic [15:0] sector_count = '0;
	logic [7:0]  status_byte  = '0;
	logic [15:0] data_word    = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  action;
	logic [9:0]  port;
	logic [15:0] value;
	logic        last;

	access_tracker_t tracker = new();
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;
	int item_count    = 0;

	ata_pio_host_sequencer #(
		.MAX_CHUNK(CHUNK_MAX),
		.SETTLE_READS(SETTLE_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.start_lba(start_lba),
		.sector_count(sector_count),
		.status_byte(status_byte),
		.data_word(data_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.port(port),
		.value(value),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: check every accepted result, then pick the next stall.
	initial begin
		access_t got;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{action, port, value, last};
				tracker.check_access(got);
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#(WATCHDOG_NS);
		$display("TEST FAILED");
		$finish;
	end

	// Offers one item and returns at the edge where it was taken. Valid stays
	// high so that a following item can go out without a gap.
	task automatic offer_item(input logic [1:0] k, input logic [27:0] lba,
			input logic [15:0] cnt, input logic [7:0] st, input logic [15:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		start_lba    <= lba;
		sector_count <= cnt;
		status_byte  <= st;
		data_word    <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.predict_item(k, lba, cnt, st, w);
	endtask

	task automatic send_start(input logic [1:0] k, input logic [27:0] lba,
			input logic [15:0] cnt);
		offer_item(k, lba, cnt, 8'($urandom), 16'($urandom));
		item_count++;
	endtask

	task automatic send_status(input logic [7:0] s);
		offer_item(ataseq_pkg::KIND_STATUS, 28'($urandom), 16'($urandom), s, 16'($urandom));
		item_count++;
	endtask

	task automatic send_word(input logic [15:0] w);
		offer_item(ataseq_pkg::KIND_DATA, 28'($urandom), 16'($urandom), 8'($urandom), w);
		item_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [19:0] lim);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.limit = lim;
	endtask

	function automatic logic [7:0] busy_status();
		logic [7:0] s;
		s = 8'($urandom);
		s[ataseq_pkg::ST_BSY] = 1'b1;
		return s;
	endfunction

	function automatic logic [7:0] ready_status();
		logic [7:0] s;
		s = 8'($urandom);
		s[ataseq_pkg::ST_BSY] = 1'b0;
		s[ataseq_pkg::ST_ERR] = 1'b0;
		s[ataseq_pkg::ST_DF] = 1'b0;
		return s;
	endfunction

	function automatic logic [7:0] drq_status();
		logic [7:0] s;
		s = ready_status();
		s[ataseq_pkg::ST_DRQ] = 1'b1;
		return s;
	endfunction

	// A poll that neither fails nor opens a data phase while waiting for DRQ.
	function automatic logic [7:0] quiet_poll();
		logic [7:0] s;
		s = 8'($urandom);
		s[ataseq_pkg::ST_ERR] = 1'b0;
		s[ataseq_pkg::ST_DF] = 1'b0;
		if (!s[ataseq_pkg::ST_BSY])
			s[ataseq_pkg::ST_DRQ] = 1'b0;
		return s;
	endfunction

	function automatic logic [7:0] fault_status(input bit busy_ok);
		logic [7:0] s;
		s = 8'($urandom);
		if (!busy_ok)
			s[ataseq_pkg::ST_BSY] = 1'b0;
		if (!s[ataseq_pkg::ST_ERR] && !s[ataseq_pkg::ST_DF])
			s[$urandom_range(1) ? ataseq_pkg::ST_ERR : ataseq_pkg::ST_DF] = 1'b1;
		return s;
	endfunction

	function automatic logic [27:0] rand_lba();
		case ($urandom_range(7))
			0: return 28'd0;
			1: return 28'hFFFFFFF;
			default: return 28'($urandom);
		endcase
	endfunction

	// Now and then an item the sequencer must ignore in its current state.
	task automatic stray_items();
		logic [1:0] k;
		k = 2'($urandom_range(3));
		if (tracker.state == SEQ_IDLE)
			k = k[0] ? ataseq_pkg::KIND_DATA : ataseq_pkg::KIND_STATUS;
		else if (tracker.state == SEQ_DATA) begin
			if (k == ataseq_pkg::KIND_DATA)
				k = ataseq_pkg::KIND_STATUS;
		end else if (k == ataseq_pkg::KIND_STATUS)
			k = ataseq_pkg::KIND_DATA;
		if ($urandom_range(9) == 0)
			offer_item(k, 28'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// A request that ends before any sector data moves.
	task automatic run_request();
		logic [1:0]  k;
		logic [15:0] cnt;
		int          n;
		k = $urandom_range(1) ? ataseq_pkg::KIND_START_WRITE : ataseq_pkg::KIND_START_READ;
		case ($urandom_range(7))
			0: cnt = 16'd0;
			1: cnt = 16'hFFFF;
			2, 3: cnt = 16'($urandom_range(3, 1));
			default: cnt = 16'($urandom);
		endcase
		send_start(k, rand_lba(), cnt);
		stray_items();
		n = int'($urandom_range(3));
		while (n > 0 && tracker.state == SEQ_WAIT_READY) begin
			send_status(busy_status());
			stray_items();
			n--;
		end
		if (tracker.state != SEQ_WAIT_READY)
			return;
		if ($urandom_range(4) == 0) begin
			send_status(fault_status(1'b0));
			return;
		end
		send_status(ready_status());
		stray_items();
		n = int'($urandom_range(3));
		while (n > 0 && tracker.state == SEQ_WAIT_DRQ) begin
			send_status(quiet_poll());
			stray_items();
			n--;
		end
		if (tracker.limit <= 8) begin
			while (tracker.state == SEQ_WAIT_DRQ)
				send_status(quiet_poll());
		end else if (tracker.state == SEQ_WAIT_DRQ)
			send_status(fault_status(1'b1));
	endtask

	// A one-sector request carried through to its end; needs a large poll limit.
	task automatic run_sector(input logic [1:0] k);
		int i;
		send_start(k, rand_lba(), 16'd1);
		repeat ($urandom_range(2)) send_status(busy_status());
		send_status(ready_status());
		repeat ($urandom_range(2)) send_status(quiet_poll());
		send_status(drq_status());
		for (i = 0; i < int'(ataseq_pkg::WORDS_PER_SECTOR); i++) begin
			send_word(16'($urandom));
			stray_items();
		end
		if (k == ataseq_pkg::KIND_START_WRITE) begin
			repeat ($urandom_range(2)) send_status(busy_status());
			send_status($urandom_range(3) == 0 ? fault_status(1'b0) : ready_status());
		end
	endtask

	task automatic run_requests(input int budget);
		int target;
		target = item_count + budget;
		while (item_count < target) begin
			stray_items();
			run_request();
		end
	endtask

	task automatic run_directed();
		send_status(8'hFF);
		send_word(16'hFFFF);
		send_start(ataseq_pkg::KIND_START_READ, 28'hFFFFFFF, 16'd0);
		send_start(ataseq_pkg::KIND_START_WRITE, 28'd0, 16'hFFFF);
		// A second start while the first request is open is dropped.
		send_start(ataseq_pkg::KIND_START_READ, 28'h1234567, 16'd5);
		send_status(8'h80);
		send_status(8'h21);
		send_start(ataseq_pkg::KIND_START_READ, 28'hFFFFFFF, 16'd1);
		send_status(8'h00);
		send_word(16'h0000);
		send_status(8'h88);
		// ERR is honored even with BSY set while waiting for DRQ.
		send_status(8'h81);
		send_start(ataseq_pkg::KIND_START_WRITE, 28'h0ABCDEF, 16'd300);
		send_status(8'h58);
		send_status(8'h20);
		wait_drained();
		write_limit(20'd1);
		send_start(ataseq_pkg::KIND_START_READ, 28'd5, 16'd2);
		send_status(8'h80);
		send_start(ataseq_pkg::KIND_START_WRITE, 28'h8000000, 16'd1);
		send_status(8'h50);
		send_status(8'h00);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Full rate with a long receiver hold so the input side backs up.
		wait_drained();
		write_limit(20'd2);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		run_requests(50);

		wait_drained();
		write_limit(ataseq_pkg::POLL_MAX);
		send_idle_pct = 87;
		stall_pct = 0;
		run_requests(10);

		wait_drained();
		write_limit(ataseq_pkg::POLL_LIMIT_RESET);
		send_idle_pct = 0;
		stall_pct = 87;
		run_sector(ataseq_pkg::KIND_START_WRITE);
		run_requests(10);

		// A limit of zero behaves like one.
		wait_drained();
		write_limit(20'd0);
		send_idle_pct = 20;
		stall_pct = 20;
		run_requests(20);
		wait_drained();
		run_requests(20);

		wait_drained();
		$display("Sent %0d items (%0d ignored by the sequencer), checked %0d results.",
			tracker.items_seen, tracker.ignored, tracker.checked);
		$display("Seen: %0d chunk setups, %0d sectors, %0d flushes, %0d done,",
			tracker.n_chunk, tracker.n_sector, tracker.n_flush, tracker.n_done);
		$display("      %0d device errors, %0d timeouts.",
			tracker.n_device, tracker.n_timeout);
		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ataseq_pkg.sv
design/ataseq_ctrl.sv
design/ataseq_emit.sv
design/ata_pio_host_sequencer.sv
verif/testbench.sv
